@@ design/nncf_pkg.sv @@
// Package with the shared types and constants of the nearest note finder.
`default_nettype none
package nncf_pkg;
    localparam int FreqW  = 16;
    localparam int LogW   = 32;
    localparam int CentsW = 8;
    localparam logic [0:0] ActLoad  = 1'b0;
    localparam logic [0:0] ActQuery = 1'b1;
    localparam logic [0:0] RegNotesInUse = 1'b0;
    localparam logic [0:0] RegMidiBase   = 1'b1;
    localparam logic [10:0] CentsScale = 11'd1200;

    // Handshake between the sequencer and the log2 unit.
    typedef struct packed {
        logic             start;
        logic [FreqW-1:0] x;
    } t_log_req;

    typedef struct packed {
        logic            done;
        logic [LogW-1:0] y;
    } t_log_rsp;
endpackage
`default_nettype wire

@@ design/nearest_note_cents_finder_unit.sv @@
// Top level of the nearest note and cents finder.
// A load result is valid in the cycle after its word is taken; a query result follows a
// search of s steps (at most floor(log2(used))+1, so 8 at 128 notes) and the log2 passes.
// One word at a time; the next word is taken only after the result has left.
// Each search step passes through S_RD and S_CMP; the two log2 passes run one after the other.
// Reset is synchronous and active low; it restores the control and configuration registers, the table is undefined.
`default_nettype none
module nearest_note_cents_finder_unit #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: entry_index[6:0], entry_freq[22:7], measured_freq[38:23], zero fill
    input  wire  [39:0] s_axis_tdata,
    // tuser: action
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: note_slot[6:0], midi_note[14:7], expected_hz[30:15], deviation_cents[38:31]
    output logic [39:0] m_axis_tdata,
    // tuser: is_query
    output logic        m_axis_tuser,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    // Signed index wide enough for -1 .. depth.
    localparam int IW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CMP, S_FIX, S_RDL, S_RDP, S_PICK,
        S_LOGF, S_LOGE, S_MUL, S_OUT
    } t_state;

    t_state r_state;
    logic [7:0]  r_used_cfg;
    logic [6:0]  r_midi_base;
    logic [15:0] r_f;
    logic signed [IW-1:0] r_low, r_high, r_mid;
    logic [IW-1:0] r_used;
    logic [15:0] r_dl_freq, r_e;
    logic [AW-1:0] r_idx;
    logic [31:0] r_logf;
    logic signed [44:0] r_prod;
    logic        r_wait;
    logic [AW-1:0] w_addr;
    logic        w_we;
    logic [15:0] w_rdata;
    logic [15:0] w_dl, w_dp;
    logic signed [44:0] w_mag;
    logic [20:0] w_q;
    logic signed [nncf_pkg::CentsW-1:0] w_cents;
    nncf_pkg::t_log_req w_lreq;
    nncf_pkg::t_log_rsp w_lrsp;
    logic signed [IW-1:0] w_lowc;
    logic signed [IW-1:0] w_mid;

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_cfg  <= 8'd88;
            r_midi_base <= 7'd21;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nncf_pkg::RegNotesInUse: r_used_cfg  <= i_cfg_data;
                nncf_pkg::RegMidiBase:   r_midi_base <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // The midpoint is presented to the RAM in S_RD, so the
    // compare in S_CMP sees that entry.
    assign w_mid = (r_low + r_high) >>> 1;

    // The RAM is addressed by the load slot, the search midpoint or a neighbour.
    always_comb begin
        w_addr = r_mid[AW-1:0];
        if (r_state == S_IDLE) begin
            w_addr = AW'(s_axis_tdata[6:0]);
        end else if (r_state == S_RD) begin
            w_addr = w_mid[AW-1:0];
        end else if (r_state == S_FIX || r_state == S_RDL) begin
            w_addr = w_lowc[AW-1:0];
        end else if (r_state == S_RDP) begin
            w_addr = AW'(r_low - 1);
        end else if (r_state == S_PICK) begin
            w_addr = r_idx;
        end
    end
    assign w_we = s_axis_tvalid && s_axis_tready && (s_axis_tuser == nncf_pkg::ActLoad)
                  && ({2'b0, s_axis_tdata[6:0]} < 9'(TABLE_DEPTH));

    nncf_ram #(.Width(16), .Depth(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(s_axis_tdata[22:7]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_lowc = r_low;
        if (r_low < IW'(1)) w_lowc = IW'(1);
        if (r_low > $signed(r_used) - IW'(1)) w_lowc = $signed(r_used) - IW'(1);
    end

    assign w_dl = (r_dl_freq > r_f) ? r_dl_freq - r_f : r_f - r_dl_freq;
    assign w_dp = (w_rdata > r_f) ? w_rdata - r_f : r_f - w_rdata;

    assign w_lreq = {(r_state == S_LOGF || r_state == S_LOGE) && r_wait,
                     (r_state == S_LOGF) ? r_f : r_e};

    nncf_log2 u_log (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_lreq),
        .o_rsp  (w_lrsp)
    );

    assign w_mag = (r_prod < 0) ? -r_prod : r_prod;
    assign w_q   = w_mag[44:24];
    always_comb begin
        if (r_f == 16'd0) begin
            w_cents = -8'sd128;
        end else if (r_e == 16'd0) begin
            w_cents = 8'sd127;
        end else if (r_prod < 0) begin
            w_cents = (w_q > 21'd128) ? -8'sd128 : 8'(-$signed({1'b0, w_q[7:0]}));
        end else begin
            w_cents = (w_q > 21'd127) ? 8'sd127 : 8'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            r_wait        <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_f <= s_axis_tdata[38:23];
                        if (s_axis_tuser == nncf_pkg::ActLoad) begin
                            m_axis_tvalid <= 1'b1;
                            m_axis_tuser  <= 1'b0;
                            m_axis_tdata  <= '0;
                        end else begin
                            if (r_used_cfg < 8'd2) r_used <= IW'(2);
                            else if ({1'b0, r_used_cfg} > 9'(TABLE_DEPTH))
                                r_used <= IW'(TABLE_DEPTH);
                            else r_used <= IW'(r_used_cfg);
                            r_low  <= '0;
                            r_high <= (r_used_cfg < 8'd2) ? IW'(1)
                                : ({1'b0, r_used_cfg} > 9'(TABLE_DEPTH))
                                ? IW'(TABLE_DEPTH - 1) : IW'(r_used_cfg) - IW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_low <= r_high) begin
                        r_mid   <= w_mid;
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_FIX;
                    end
                end
                S_CMP: begin
                    if (r_f < w_rdata) r_high <= r_mid - IW'(1);
                    else r_low <= r_mid + IW'(1);
                    r_state <= S_RD;
                end
                S_FIX: begin
                    r_low   <= w_lowc;
                    r_state <= S_RDL;
                end
                S_RDL: begin
                    r_state <= S_RDP;
                end
                S_RDP: begin
                    r_dl_freq <= w_rdata;
                    r_state   <= S_PICK;
                end
                S_PICK: begin
                    if (w_dl < w_dp) begin
                        r_idx <= r_low[AW-1:0];
                        r_e   <= r_dl_freq;
                    end else begin
                        r_idx <= AW'(r_low - 1);
                        r_e   <= w_rdata;
                    end
                    r_wait  <= 1'b1;
                    r_state <= S_LOGF;
                end
                S_LOGF: begin
                    r_wait <= 1'b0;
                    if (w_lrsp.done) begin
                        r_logf  <= w_lrsp.y;
                        r_wait  <= 1'b1;
                        r_state <= S_LOGE;
                    end
                end
                S_LOGE: begin
                    r_wait <= 1'b0;
                    if (w_lrsp.done) begin
                        r_prod  <= 45'($signed({1'b0, r_logf}) - $signed({1'b0, w_lrsp.y}))
                                   * $signed({1'b0, nncf_pkg::CentsScale});
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tuser  <= 1'b1;
                    m_axis_tdata  <= {1'b0, w_cents, r_e,
                                      8'(r_idx) + {1'b0, r_midi_base}, 7'(r_idx)};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("input taken while busy");
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 40'd0) else $error("load ack");
`endif
endmodule
`default_nettype wire

@@ design/nncf_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module nncf_ram #(
    parameter int Width = 16,
    parameter int Depth = 128
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(Depth)-1:0] i_addr,
    input  wire  [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ design/nncf_log2.sv @@
// Bit-serial log2 in Q8.24: leading-one position, then one squaring per cycle.
`default_nettype none
module nncf_log2 (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  nncf_pkg::t_log_req i_req,
    output nncf_pkg::t_log_rsp o_rsp
);
    logic [32:0] r_y;
    logic [3:0]  r_p;
    logic [23:0] r_frac;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [3:0]  n_p;
    logic [65:0] w_sq;
    logic [34:0] w_sh;

    always_comb begin
        n_p = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (i_req.x[k]) begin
                n_p = 4'(k);
            end
        end
    end

    assign w_sq = r_y * r_y;
    assign w_sh = w_sq[65:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_p    <= n_p;
                r_frac <= '0;
                r_y    <= 33'({17'd0, i_req.x} << (5'd31 - {1'b0, n_p}));
            end else if (r_busy) begin
                if (w_sh[34:32] != 3'd0) begin
                    r_y    <= w_sh[33:1];
                    r_frac <= {r_frac[22:0], 1'b1};
                end else begin
                    r_y    <= w_sh[32:0];
                    r_frac <= {r_frac[22:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = {r_done, 4'd0, r_p, r_frac};
endmodule
`default_nettype wire

@@ sim/tb_nearest_note_cents_finder_unit.sv @@
// Testbench of the nearest note and cents finder: table loads, queries and register writes.
`timescale 1ns / 1ps
module tb_nearest_note_cents_finder_unit;

    localparam int Depth = 128;
    localparam longint CycleLimit = 2000000;

    // One input word and one expected answer, both at the block's widths.
    typedef struct {
        logic [0:0] action;
        logic [6:0] slot;
        logic [15:0] efreq;
        logic [15:0] mfreq;
    } t_word;

    typedef struct {
        logic is_query;
        logic [6:0] slot;
        logic [7:0] midi;
        logic [15:0] hz;
        logic signed [7:0] cents;
        logic typed_in;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [0:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    always #10 i_clk = ~i_clk;

    nearest_note_cents_finder_unit #(.TABLE_DEPTH(Depth)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the block's table and registers.
    logic [15:0] tuning_table [Depth];
    logic [7:0] notes_used;
    logic [6:0] base_note;

    t_answer pending_answers[$];
    int error_count = 0;
    longint cycle_count = 0;
    bit quiet_phase = 1'b0;
    bit hold_receiver = 1'b0;
    int rx_idle = 0;

    // log2 in Q8.24 by repeated squaring of the normalised mantissa.
    function automatic logic [31:0] log2_fixed(input logic [15:0] x);
        int lead;
        logic [63:0] m;
        logic [23:0] frac;
        lead = 0;
        for (int b = 0; b < 16; b++) if (x[b]) lead = b;
        m = 64'(x) << (31 - lead);
        frac = '0;
        for (int r = 0; r < 24; r++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {3'b0, 5'(lead), frac};
    endfunction

    function automatic logic signed [7:0] cents_off(input logic [15:0] f, input logic [15:0] e);
        longint d;
        longint q;
        if (f == 0) return -8'sd128;
        if (e == 0) return 8'sd127;
        d = longint'(log2_fixed(f)) - longint'(log2_fixed(e));
        d = d * 1200;
        q = (d < 0 ? -d : d) >>> 24;
        if (d < 0) q = -q;
        if (q > 127) q = 127;
        if (q < -128) q = -128;
        return 8'(q);
    endfunction

    // Works out the answer to one word and updates the shadow table on loads.
    function automatic t_answer nearest_note(input t_word w);
        t_answer a;
        int used, lo, hi, mid, pick, dl, dp;
        a = '{default: '0};
        if (w.action == nncf_pkg::ActLoad) begin
            tuning_table[w.slot] = w.efreq;
            return a;
        end
        used = notes_used;
        if (used < 2) used = 2;
        if (used > Depth) used = Depth;
        lo = 0;
        hi = used - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (w.mfreq < tuning_table[mid]) hi = mid - 1;
            else lo = mid + 1;
        end
        if (lo < 1) lo = 1;
        if (lo > used - 1) lo = used - 1;
        dl = int'(tuning_table[lo]) - int'(w.mfreq);
        dp = int'(tuning_table[lo-1]) - int'(w.mfreq);
        if (dl < 0) dl = -dl;
        if (dp < 0) dp = -dp;
        pick = (dl < dp) ? lo : lo - 1;
        a.is_query = 1'b1;
        a.slot = 7'(pick);
        a.midi = 8'(pick) + 8'(base_note);
        a.hz = tuning_table[pick];
        a.cents = cents_off(w.mfreq, a.hz);
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // The sender drops its valid for the length of an idle burst.
    task automatic idle_burst();
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    // Sends one word and queues its answer; a typed-in answer replaces the predicted one.
    // Valid stays high afterwards so that words can follow back to back.
    task automatic send_word(input t_word w, input bit typed, input t_answer typed_ans);
        t_answer a;
        idle_burst();
        s_axis_tdata <= {1'b0, w.mfreq, w.efreq, w.slot};
        s_axis_tuser <= w.action;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        a = nearest_note(w);
        if (typed) begin
            if (typed_ans.is_query != a.is_query || typed_ans.slot != a.slot ||
                typed_ans.midi != a.midi || typed_ans.hz != a.hz ||
                typed_ans.cents != a.cents)
                report_mismatch("typed answer vs predictor", 0, 1);
            a = typed_ans;
            a.typed_in = 1'b1;
        end
        pending_answers.push_back(a);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [7:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == nncf_pkg::RegNotesInUse) notes_used = val;
        else base_note = val[6:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits for every answer, then for the query latency, so registers can be written.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic load(input int slot, input logic [15:0] hz);
        t_word w;
        w = '{nncf_pkg::ActLoad, 7'(slot), hz, 16'($urandom)};
        send_word(w, 1'b0, '{default: '0});
    endtask

    task automatic query(input logic [15:0] hz);
        t_word w;
        w = '{nncf_pkg::ActQuery, 7'($urandom), 16'($urandom), hz};
        send_word(w, 1'b0, '{default: '0});
    endtask

    // Loads a fresh non-decreasing table across all slots with random spacing.
    task automatic load_sorted_table(input int start_hz, input int max_step);
        int hz;
        hz = start_hz;
        for (int s = 0; s < Depth; s++) begin
            load(s, 16'(hz));
            hz = hz + $urandom_range(0, max_step);
            if (hz > 65535) hz = 65535;
        end
    endtask

    // Picks a query near a used entry most of the time, otherwise anywhere.
    function automatic logic [15:0] pick_query();
        int used, s, v;
        used = notes_used < 2 ? 2 : notes_used;
        if (used > Depth) used = Depth;
        s = $urandom_range(0, used - 1);
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'd0;
            2: return 16'hFFFF;
            default: begin
                v = int'(tuning_table[s]) + $urandom_range(0, 40) - 20;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
        endcase
    endfunction

    // Receiver: idle bursts of random length, one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_receiver) m_axis_tready <= 1'b0;
        else if (quiet_phase) m_axis_tready <= 1'b1;
        else if (rx_idle > 0) begin
            rx_idle = rx_idle - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_idle = $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end else m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_answer want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("answer with none expected", m_axis_tdata, 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tuser !== want.is_query)
                    report_mismatch("is_query", m_axis_tuser, want.is_query);
                if (m_axis_tdata[6:0] !== want.slot)
                    report_mismatch("note_slot", m_axis_tdata[6:0], want.slot);
                if (m_axis_tdata[14:7] !== want.midi)
                    report_mismatch("midi_note", m_axis_tdata[14:7], want.midi);
                if (m_axis_tdata[30:15] !== want.hz)
                    report_mismatch("expected_hz", m_axis_tdata[30:15], want.hz);
                if ($signed(m_axis_tdata[38:31]) !== want.cents)
                    report_mismatch("deviation_cents", $signed(m_axis_tdata[38:31]), want.cents);
            end
        end
        if (cycle_count >= CycleLimit) begin
            $display("tb_nearest_note_cents_finder_unit: done, errors");
            $finish;
        end
    end

    // Long hold-off: the sender keeps offering words so the block stalls its input.
    initial begin
        wait (cycle_count == 30000);
        @(negedge i_clk);
        hold_receiver = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_receiver = 1'b0;
    end

    // Directed words: loads, extremes and zero frequencies on a small known table.
    t_word directed_words [] = '{
        '{nncf_pkg::ActLoad, 7'd0, 16'd0, 16'hFFFF},
        '{nncf_pkg::ActLoad, 7'd1, 16'd100, 16'd0},
        '{nncf_pkg::ActLoad, 7'd2, 16'd200, 16'd0},
        '{nncf_pkg::ActLoad, 7'd3, 16'd400, 16'd0},
        '{nncf_pkg::ActLoad, 7'd127, 16'hFFFF, 16'd0},
        '{nncf_pkg::ActQuery, 7'd0, 16'd0, 16'd0},
        '{nncf_pkg::ActQuery, 7'h7F, 16'hFFFF, 16'd100},
        '{nncf_pkg::ActQuery, 7'd0, 16'd0, 16'd200},
        '{nncf_pkg::ActQuery, 7'd0, 16'd0, 16'd150},
        '{nncf_pkg::ActQuery, 7'd0, 16'd0, 16'd1},
        '{nncf_pkg::ActQuery, 7'd0, 16'd0, 16'hFFFF},
        '{nncf_pkg::ActQuery, 7'd0, 16'd0, 16'd283}
    };
    // Typed-in answers where obvious; the rest come from the predictor.
    bit directed_typed [] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0};
    t_answer directed_answers [] = '{
        '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
        '{1, 7'd0, 8'd2, 16'd0, -8'sd128, 0},
        '{1, 7'd1, 8'd3, 16'd100, 8'sd0, 0},
        '{1, 7'd2, 8'd4, 16'd200, 8'sd0, 0},
        '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0}
    };

    initial begin
        foreach (tuning_table[k]) tuning_table[k] = '0;
        notes_used = 8'd88;
        base_note = 7'd21;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Small table of four entries; base note two.
        write_register(nncf_pkg::RegNotesInUse, 8'd4);
        write_register(nncf_pkg::RegMidiBase, 7'd2);
        foreach (directed_words[k])
            send_word(directed_words[k], directed_typed[k], directed_answers[k]);
        drain();

        // Random phases over several register settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_register(nncf_pkg::RegNotesInUse, 8'd2);
                    write_register(nncf_pkg::RegMidiBase, 8'd0);
                end
                1: begin
                    write_register(nncf_pkg::RegNotesInUse, 8'd128);
                    write_register(nncf_pkg::RegMidiBase, 8'd127);
                end
                2: begin
                    write_register(nncf_pkg::RegNotesInUse, 8'd88);
                    write_register(nncf_pkg::RegMidiBase, 8'd21);
                end
                3: begin
                    write_register(nncf_pkg::RegNotesInUse, 8'd0);
                    write_register(nncf_pkg::RegMidiBase, 8'd64);
                end
                4: begin
                    write_register(nncf_pkg::RegNotesInUse, 8'hFF);
                    write_register(nncf_pkg::RegMidiBase, 8'd100);
                end
                default: begin
                    write_register(nncf_pkg::RegNotesInUse, 8'($urandom_range(2, 128)));
                    write_register(nncf_pkg::RegMidiBase, 8'($urandom_range(0, 127)));
                    quiet_phase = 1'b1;
                end
            endcase
            load_sorted_table($urandom_range(0, 50), (phase % 2) ? 1000 : 30);
            for (int n = 0; n < 112; n++) begin
                if ($urandom_range(0, 9) == 0)
                    // Overwrite an entry at random; the table may become unsorted.
                    load($urandom_range(0, Depth - 1), 16'($urandom));
                else
                    query(pick_query());
            end
            drain();
        end

        if (error_count == 0)
            $display("tb_nearest_note_cents_finder_unit: done, clean");
        else
            $display("tb_nearest_note_cents_finder_unit: done, errors");
        $finish;
    end
endmodule

@@ sim.f @@
design/nncf_pkg.sv
design/nncf_ram.sv
design/nncf_log2.sv
design/nearest_note_cents_finder_unit.sv
sim/tb_nearest_note_cents_finder_unit.sv
